// ===== hw/rtl/cmma_pkg.sv =====
// ---------------------------------------------------------------------------
// cmma_pkg
// Shared constants, codes and types of the complex matrix multiply-accumulate.
// ---------------------------------------------------------------------------
package cmma_pkg;

    localparam int MAX_DIM   = 64;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int DIM_W     = 7;
    localparam int PART_W    = 32;
    localparam int ELEM_W    = 2 * PART_W;
    localparam int PROD_W    = 2 * PART_W;
    localparam int TERM_W    = PROD_W + 1;
    localparam int ACC_W     = 72;
    localparam int FRAC_BITS = 16;
    localparam int SHR_W     = ACC_W - FRAC_BITS;
    localparam int SUM_W     = SHR_W + 1;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_WR_A = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_C = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RD_C = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_OF_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_OF_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_MAX) ? DIM_MAX : d;
    endfunction

endpackage

// ===== hw/rtl/cmma_in_if.sv =====
// ---------------------------------------------------------------------------
// cmma_in_if
// Command word channel: valid/ready with command, indices and element.
// ---------------------------------------------------------------------------
interface cmma_in_if;
    import cmma_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [CMD_W-1:0]  cmd;
    logic        [IDX_W-1:0]  row_index;
    logic        [IDX_W-1:0]  col_index;
    logic signed [PART_W-1:0] real_part;
    logic signed [PART_W-1:0] imag_part;

    modport source (output valid, cmd, row_index, col_index, real_part, imag_part,
                    input ready);
    modport sink   (input valid, cmd, row_index, col_index, real_part, imag_part,
                    output ready);
endinterface

// ===== hw/rtl/cmma_out_if.sv =====
// ---------------------------------------------------------------------------
// cmma_out_if
// Read result channel: valid/ready with one complex element of C.
// ---------------------------------------------------------------------------
interface cmma_out_if;
    import cmma_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PART_W-1:0] out_real;
    logic signed [PART_W-1:0] out_imag;

    modport source (output valid, out_real, out_imag, input ready);
    modport sink   (input valid, out_real, out_imag, output ready);
endinterface

// ===== hw/rtl/cmma_mac_unit.sv =====
// ---------------------------------------------------------------------------
// cmma_mac_unit
// Complex product pipeline, exact accumulator and saturating C update.
// ---------------------------------------------------------------------------
module cmma_mac_unit
    import cmma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctl          i_ctl,
    input  logic [ELEM_W-1:0] i_a,
    input  logic [ELEM_W-1:0] i_b,
    input  logic [ELEM_W-1:0] i_c,
    output logic              o_done,
    output logic [ELEM_W-1:0] o_c_new
);

    t_mac_ctl                 r_ctl2;
    t_mac_ctl                 r_ctl3;
    logic                     r_done;
    logic signed [PROD_W-1:0] r_p_rr;
    logic signed [PROD_W-1:0] r_p_ii;
    logic signed [PROD_W-1:0] r_p_ri;
    logic signed [PROD_W-1:0] r_p_ir;
    logic signed [TERM_W-1:0] r_t_re;
    logic signed [TERM_W-1:0] r_t_im;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;

    logic signed [PART_W-1:0] w_ar;
    logic signed [PART_W-1:0] w_ai;
    logic signed [PART_W-1:0] w_br;
    logic signed [PART_W-1:0] w_bi;
    logic signed [ACC_W-1:0]  w_t_re_x;
    logic signed [ACC_W-1:0]  w_t_im_x;

    assign w_ar = i_a[PART_W-1:0];
    assign w_ai = i_a[ELEM_W-1:PART_W];
    assign w_br = i_b[PART_W-1:0];
    assign w_bi = i_b[ELEM_W-1:PART_W];

    assign w_t_re_x = {{(ACC_W-TERM_W){r_t_re[TERM_W-1]}}, r_t_re};
    assign w_t_im_x = {{(ACC_W-TERM_W){r_t_im[TERM_W-1]}}, r_t_im};

    function automatic logic [PART_W-1:0] finish_part(input logic [ACC_W-1:0] acc,
                                                      input logic [PART_W-1:0] c);
        logic [SHR_W-1:0] sh;
        logic [SUM_W-1:0] sum;
        sh  = acc[ACC_W-1:FRAC_BITS];
        sum = {sh[SHR_W-1], sh} + {{(SUM_W-PART_W){c[PART_W-1]}}, c};
        if ((&sum[SUM_W-1:PART_W-1]) || !(|sum[SUM_W-1:PART_W-1])) begin
            return sum[PART_W-1:0];
        end else if (sum[SUM_W-1]) begin
            return {1'b1, {(PART_W-1){1'b0}}};
        end else begin
            return {1'b0, {(PART_W-1){1'b1}}};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= r_ctl2;
            r_done <= r_ctl3.valid && r_ctl3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_rr <= w_ar * w_br;
        r_p_ii <= w_ai * w_bi;
        r_p_ri <= w_ar * w_bi;
        r_p_ir <= w_ai * w_br;
        r_t_re <= TERM_W'(r_p_rr) - TERM_W'(r_p_ii);
        r_t_im <= TERM_W'(r_p_ri) + TERM_W'(r_p_ir);
        if (r_ctl3.valid) begin
            if (r_ctl3.first) begin
                r_acc_re <= w_t_re_x;
                r_acc_im <= w_t_im_x;
            end else begin
                r_acc_re <= r_acc_re + w_t_re_x;
                r_acc_im <= r_acc_im + w_t_im_x;
            end
        end
    end

    assign o_done  = r_done;
    assign o_c_new = {finish_part(r_acc_im, i_c[ELEM_W-1:PART_W]),
                      finish_part(r_acc_re, i_c[PART_W-1:0])};

endmodule

// ===== hw/rtl/complex_matrix_multiply_accumulate.sv =====
// ---------------------------------------------------------------------------
// complex_matrix_multiply_accumulate
// C += A * B on complex Q16.16 matrices held in three on-chip memories.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one command word: write an element of A, B or C, start a
//   run, or read one element of C. Only a read gives a word on o_out.
//   Dimensions (rows_of_a, inner_length, cols_of_b) are to be written on the
//   cfg port only while the block is idle; the block does not enforce this.
//   Zero makes a run a no-op, above 64 counts as 64.
//   Writes are accepted back to back while i_in is ready. A read is
//   accepted, its word is loaded into the output register once that
//   register is free, and the block takes the next word after that; the read
//   data is held until o_out accepts it while later writes still flow.
//   A run walks M*P elements of C; each takes N A/B memory reads in S_MAC
//   followed by the product, accumulate and C write-back pipeline in S_WAIT.
//   i_in is not ready during a run.
//   Reset clears control and sets all dimensions to 64; memory contents are
//   undefined until written. A stalled o_out holds its word.
// ---------------------------------------------------------------------------
module complex_matrix_multiply_accumulate
    import cmma_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cmma_in_if.sink              i_in,
    cmma_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_MAC, S_WAIT} t_state;

    t_state              r_state;
    logic [DIM_W-1:0]    r_rows;
    logic [DIM_W-1:0]    r_inner;
    logic [DIM_W-1:0]    r_cols;
    logic [IDX_W-1:0]    r_m;
    logic [IDX_W-1:0]    r_n;
    logic [IDX_W-1:0]    r_p;
    logic                r_rd_pend;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic                r_out_valid;
    logic [PART_W-1:0]   r_out_re;
    logic [PART_W-1:0]   r_out_im;
    t_mac_ctl            r_ctl1;
    logic [ELEM_W-1:0]   r_a_q;
    logic [ELEM_W-1:0]   r_b_q;
    logic [ELEM_W-1:0]   r_c_q;

    logic [ELEM_W-1:0]   mem_a [DEPTH];
    logic [ELEM_W-1:0]   mem_b [DEPTH];
    logic [ELEM_W-1:0]   mem_c [DEPTH];

    logic [DIM_W-1:0]    w_m_n;
    logic [DIM_W-1:0]    w_n_n;
    logic [DIM_W-1:0]    w_p_n;
    logic                w_accept;
    logic [ADDR_W-1:0]   w_in_addr;
    logic [ELEM_W-1:0]   w_in_elem;
    logic                w_n_last;
    logic                w_p_last;
    logic                w_m_last;
    logic                w_out_free;
    t_mac_ctl            w_ctl0;
    logic [ADDR_W-1:0]   w_c_raddr;
    logic                w_c_we;
    logic [ADDR_W-1:0]   w_c_waddr;
    logic [ELEM_W-1:0]   w_c_wdata;
    logic                w_done;
    logic [ELEM_W-1:0]   w_c_new;

    assign w_m_n = clamp_dim(r_rows);
    assign w_n_n = clamp_dim(r_inner);
    assign w_p_n = clamp_dim(r_cols);

    assign i_in.ready = (r_state == S_IDLE) && !r_rd_pend;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_addr  = {i_in.row_index, i_in.col_index};
    assign w_in_elem  = {i_in.imag_part, i_in.real_part};

    assign w_n_last = ({1'b0, r_n} == w_n_n - DIM_W'(1));
    assign w_p_last = ({1'b0, r_p} == w_p_n - DIM_W'(1));
    assign w_m_last = ({1'b0, r_m} == w_m_n - DIM_W'(1));

    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_ctl0.valid = (r_state == S_MAC);
    assign w_ctl0.first = (r_n == '0);
    assign w_ctl0.last  = w_n_last;

    always_comb begin
        if (r_state != S_IDLE) begin
            w_c_raddr = {r_m, r_p};
        end else if (r_rd_pend) begin
            w_c_raddr = r_rd_addr;
        end else begin
            w_c_raddr = w_in_addr;
        end
    end

    always_comb begin
        if (r_state == S_WAIT) begin
            w_c_we    = w_done;
            w_c_waddr = {r_m, r_p};
            w_c_wdata = w_c_new;
        end else begin
            w_c_we    = w_accept && (i_in.cmd == CMD_WR_C);
            w_c_waddr = w_in_addr;
            w_c_wdata = w_in_elem;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.cmd == CMD_WR_A)) begin
            mem_a[w_in_addr] <= w_in_elem;
        end
        r_a_q <= mem_a[{r_m, r_n}];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.cmd == CMD_WR_B)) begin
            mem_b[w_in_addr] <= w_in_elem;
        end
        r_b_q <= mem_b[{r_n, r_p}];
    end

    always_ff @(posedge i_clk) begin
        if (w_c_we) begin
            mem_c[w_c_waddr] <= w_c_wdata;
        end
        r_c_q <= mem_c[w_c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_MAX;
            r_inner <= DIM_MAX;
            r_cols  <= DIM_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS_OF_A:    r_rows  <= i_cfg_data;
                CFG_INNER_LENGTH: r_inner <= i_cfg_data;
                CFG_COLS_OF_B:    r_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= w_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.cmd == CMD_RD_C)) begin
            r_rd_addr <= w_in_addr;
        end
        if (r_rd_pend && w_out_free) begin
            r_out_re <= r_c_q[PART_W-1:0];
            r_out_im <= r_c_q[ELEM_W-1:PART_W];
        end
    end

    // sequencer and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m         <= '0;
            r_n         <= '0;
            r_p         <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_rd_pend && w_out_free) begin
                r_rd_pend   <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_in.cmd == CMD_RD_C)) begin
                        r_rd_pend <= 1'b1;
                    end
                    if (w_accept && (i_in.cmd == CMD_RUN) && (w_m_n != '0)
                            && (w_n_n != '0) && (w_p_n != '0)) begin
                        r_state <= S_MAC;
                        r_m     <= '0;
                        r_n     <= '0;
                        r_p     <= '0;
                    end
                end
                S_MAC: begin
                    if (w_n_last) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_n <= r_n + IDX_W'(1);
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_n <= '0;
                        if (w_p_last) begin
                            r_p <= '0;
                            if (w_m_last) begin
                                r_state <= S_IDLE;
                                r_m     <= '0;
                            end else begin
                                r_state <= S_MAC;
                                r_m     <= r_m + IDX_W'(1);
                            end
                        end else begin
                            r_state <= S_MAC;
                            r_p     <= r_p + IDX_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    cmma_mac_unit u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl1),
        .i_a     (r_a_q),
        .i_b     (r_b_q),
        .i_c     (r_c_q),
        .o_done  (w_done),
        .o_c_new (w_c_new)
    );

    assign o_out.valid    = r_out_valid;
    assign o_out.out_real = r_out_re;
    assign o_out.out_imag = r_out_im;

    a_rd_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.cmd == CMD_RD_C) |=> r_rd_pend)
        else $error("read word not held pending");

    a_rd_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend && w_out_free |=> r_out_valid && !r_rd_pend)
        else $error("pending read not loaded into output");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_WAIT)
        else $error("accumulate finished outside write-back wait");

    a_issue_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl1.valid |-> $past(r_state) == S_MAC)
        else $error("product issued outside a run");

endmodule

// ===== test/complex_matrix_multiply_accumulate_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// complex_matrix_multiply_accumulate_tb
// Drives command words into the complex C += A * B block and checks every
// read of C against a bit-exact software copy of the three matrices. Each
// phase sets the dimensions while the block is idle, fills every entry the
// run will touch, runs once or twice and reads C back, with noise words and
// random valid/ready gaps mixed in.
// ---------------------------------------------------------------------------
module complex_matrix_multiply_accumulate_tb;
    import cmma_pkg::*;

    localparam int CYCLE_LIMIT   = 800_000;
    localparam int WORD_TARGET   = 1700;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [CMD_W-1:0]     CMD_NOP_5 = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_NOP_6 = 3'd6;
    localparam logic [CMD_W-1:0]     CMD_NOP_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [PART_W-1:0] PART_MAX = 32'h7FFF_FFFF;
    localparam logic [PART_W-1:0] PART_MIN = 32'h8000_0000;
    localparam logic signed [127:0] SUM_HI = 128'sd2147483647;
    localparam logic signed [127:0] SUM_LO = -128'sd2147483648;

    typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_EDGE} value_style_t;
    typedef enum int {DIMS_ZERO, DIMS_OVER, DIMS_FULL, DIMS_MEDIUM, DIMS_SMALL} dims_mode_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PART_W-1:0] re;
        logic [PART_W-1:0] im;
    } cmd_word_t;

    typedef struct {
        logic [PART_W-1:0] re;
        logic [PART_W-1:0] im;
    } c_elem_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DIM_W-1:0]     i_cfg_data;

    cmma_in_if  cmd_if ();
    cmma_out_if rd_if ();

    complex_matrix_multiply_accumulate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if),
        .o_out      (rd_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predicted matrices and dimensions
    logic [ELEM_W-1:0] mat_a [DEPTH];
    logic [ELEM_W-1:0] mat_b [DEPTH];
    logic [ELEM_W-1:0] mat_c [DEPTH];
    logic [DIM_W-1:0]  dim_m;
    logic [DIM_W-1:0]  dim_n;
    logic [DIM_W-1:0]  dim_p;

    // stimulus bookkeeping: which entries hold a written value
    bit        a_known [DEPTH];
    bit        b_known [DEPTH];
    bit        c_known [DEPTH];
    int        c_addrs [$];

    cmd_word_t cmd_words [$];
    c_elem_t   c_reads [$];
    cmd_word_t cur_word;
    int        send_gap;
    int        hold_off;
    int        word_count;
    int        errors;
    int        cycles;
    bit        calm;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int eff_dim(input int d);
        return (d > MAX_DIM) ? MAX_DIM : d;
    endfunction

    function automatic logic [PART_W-1:0] settle_part(input logic signed [127:0] acc,
                                                      input logic [PART_W-1:0] old);
        logic signed [127:0] s;
        s = (acc >>> FRAC_BITS) + $signed(old);
        if (s > SUM_HI) return PART_MAX;
        if (s < SUM_LO) return PART_MIN;
        return s[PART_W-1:0];
    endfunction

    function automatic void accumulate_c();
        int                  m_n;
        int                  n_n;
        int                  p_n;
        logic signed [127:0] acc_re;
        logic signed [127:0] acc_im;
        logic signed [63:0]  ar;
        logic signed [63:0]  ai;
        logic signed [63:0]  br;
        logic signed [63:0]  bi;
        logic [ELEM_W-1:0]   a;
        logic [ELEM_W-1:0]   b;
        logic [ELEM_W-1:0]   c;
        m_n = eff_dim(dim_m);
        n_n = eff_dim(dim_n);
        p_n = eff_dim(dim_p);
        for (int m = 0; m < m_n; m++) begin
            for (int p = 0; p < p_n; p++) begin
                acc_re = '0;
                acc_im = '0;
                for (int n = 0; n < n_n; n++) begin
                    a  = mat_a[m * MAX_DIM + n];
                    b  = mat_b[n * MAX_DIM + p];
                    ar = $signed(a[PART_W-1:0]);
                    ai = $signed(a[ELEM_W-1:PART_W]);
                    br = $signed(b[PART_W-1:0]);
                    bi = $signed(b[ELEM_W-1:PART_W]);
                    acc_re = acc_re + ar * br - ai * bi;
                    acc_im = acc_im + ar * bi + ai * br;
                end
                c = mat_c[m * MAX_DIM + p];
                mat_c[m * MAX_DIM + p] = {settle_part(acc_im, c[ELEM_W-1:PART_W]),
                                          settle_part(acc_re, c[PART_W-1:0])};
            end
        end
    endfunction

    function automatic void apply_word(input cmd_word_t w);
        int      addr;
        c_elem_t e;
        addr = w.row * MAX_DIM + w.col;
        case (w.cmd)
            CMD_WR_A: mat_a[addr] = {w.im, w.re};
            CMD_WR_B: mat_b[addr] = {w.im, w.re};
            CMD_WR_C: mat_c[addr] = {w.im, w.re};
            CMD_RUN:  accumulate_c();
            CMD_RD_C: begin
                e.re = mat_c[addr][PART_W-1:0];
                e.im = mat_c[addr][ELEM_W-1:PART_W];
                c_reads.push_back(e);
            end
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [PART_W-1:0] got,
                                 input logic [PART_W-1:0] want);
        if (errors < 200) begin
            $display("tb: mismatch on %s: got %h, want %h", what, got, want);
        end
        errors++;
    endtask

    // word driver
    always @(posedge i_clk) begin : drive_words
        cmd_word_t nxt;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap     <= 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                apply_word(cur_word);
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (send_gap != 0) begin
                    cmd_if.valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end else if (cmd_words.size() != 0) begin
                    nxt = cmd_words.pop_front();
                    cur_word         <= nxt;
                    cmd_if.cmd       <= nxt.cmd;
                    cmd_if.row_index <= nxt.row;
                    cmd_if.col_index <= nxt.col;
                    cmd_if.real_part <= nxt.re;
                    cmd_if.imag_part <= nxt.im;
                    cmd_if.valid     <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        send_gap <= $urandom_range(1, 10);
                    end
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // read word monitor
    always @(posedge i_clk) begin : watch_reads
        c_elem_t want;
        if (!i_rst_n) begin
            rd_if.ready <= 1'b0;
            hold_off    <= 0;
        end else begin
            if (rd_if.valid && rd_if.ready) begin
                if (c_reads.size() == 0) begin
                    note_mismatch("unrequested read word", rd_if.out_real, '0);
                end else begin
                    want = c_reads.pop_front();
                    if (rd_if.out_real !== want.re) begin
                        note_mismatch("out_real", rd_if.out_real, want.re);
                    end
                    if (rd_if.out_imag !== want.im) begin
                        note_mismatch("out_imag", rd_if.out_imag, want.im);
                    end
                end
            end
            if (hold_off != 0) begin
                rd_if.ready <= 1'b0;
                hold_off    <= hold_off - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                rd_if.ready <= 1'b0;
                hold_off    <= $urandom_range(0, 9);
            end else begin
                rd_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [PART_W-1:0] pick_part(input value_style_t style);
        logic [PART_W-1:0] v;
        case (style)
            STYLE_SMALL: v = $urandom_range(0, 1 << 19) - (1 << 18);
            STYLE_EDGE: begin
                case ($urandom_range(0, 5))
                    0:       v = PART_MAX;
                    1:       v = PART_MIN;
                    2:       v = '0;
                    3:       v = '1;
                    4:       v = 1;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void push_word(input logic [CMD_W-1:0] cmd, input int row, input int col,
                                      input logic [PART_W-1:0] re, input logic [PART_W-1:0] im);
        cmd_word_t w;
        int        addr;
        w.cmd = cmd;
        w.row = row[IDX_W-1:0];
        w.col = col[IDX_W-1:0];
        w.re  = re;
        w.im  = im;
        addr  = row * MAX_DIM + col;
        cmd_words.push_back(w);
        case (cmd)
            CMD_WR_A: a_known[addr] = 1'b1;
            CMD_WR_B: b_known[addr] = 1'b1;
            CMD_WR_C: begin
                if (!c_known[addr]) begin
                    c_known[addr] = 1'b1;
                    c_addrs.push_back(addr);
                end
            end
            default: ;
        endcase
        if (cmd <= CMD_RD_C) word_count++;
    endfunction

    function automatic void push_write(input logic [CMD_W-1:0] cmd, input int row, input int col,
                                       input value_style_t style);
        push_word(cmd, row, col, pick_part(style), pick_part(style));
    endfunction

    function automatic void push_read_known();
        int addr;
        addr = c_addrs[$urandom_range(0, c_addrs.size() - 1)];
        push_word(CMD_RD_C, addr / MAX_DIM, addr % MAX_DIM, $urandom, $urandom);
    endfunction

    function automatic void push_noise(input value_style_t style);
        case ($urandom_range(0, 2))
            0: push_word(CMD_W'(CMD_NOP_5 + $urandom_range(0, 2)), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom, $urandom);
            1: push_write(CMD_W'(CMD_WR_A + $urandom_range(0, 2)), $urandom_range(0, 63),
                          $urandom_range(0, 63), style);
            default: push_read_known();
        endcase
    endfunction

    function automatic void fill_entry(input logic [CMD_W-1:0] cmd, input int row, input int col,
                                       input bit known, input value_style_t style);
        if (!known || $urandom_range(0, 1) == 0) push_write(cmd, row, col, style);
        if ($urandom_range(0, 9) == 0) push_noise(style);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROWS_OF_A:    dim_m = val;
            CFG_INNER_LENGTH: dim_n = val;
            CFG_COLS_OF_B:    dim_p = val;
            default: ;
        endcase
    endtask

    // every phase ends in a read, so an empty read queue means the run is done
    task automatic drain();
        while (cmd_words.size() != 0 || cmd_if.valid || c_reads.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int           phase;
        int           k;
        int           runs;
        int           em;
        int           en;
        int           ep;
        int           d [3];
        dims_mode_t   mode;
        value_style_t style;
        int           r;

        cmd_if.valid     = 1'b0;
        cmd_if.cmd       = CMD_WR_A;
        cmd_if.row_index = '0;
        cmd_if.col_index = '0;
        cmd_if.real_part = '0;
        cmd_if.imag_part = '0;
        rd_if.ready      = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_ROWS_OF_A;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        dim_m            = DIM_MAX;
        dim_n            = DIM_MAX;
        dim_p            = DIM_MAX;
        calm             = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: saturation both ways, floor rounding, corner indices, nops
        write_reg(CFG_ROWS_OF_A, 7'd1);
        write_reg(CFG_INNER_LENGTH, 7'd1);
        write_reg(CFG_COLS_OF_B, 7'd1);
        push_word(CMD_WR_A, 0, 0, PART_MAX, PART_MAX);
        push_word(CMD_WR_B, 0, 0, PART_MAX, PART_MIN);
        push_word(CMD_WR_C, 0, 0, PART_MAX, PART_MIN);
        push_word(CMD_RUN, 0, 0, '0, '0);
        push_word(CMD_RD_C, 0, 0, '0, '0);
        push_word(CMD_RD_C, 0, 0, '1, '1);
        push_word(CMD_WR_C, 63, 63, PART_MIN, PART_MAX);
        push_word(CMD_WR_C, 0, 63, '0, '1);
        push_word(CMD_WR_C, 63, 0, 1, $urandom);
        push_word(CMD_RD_C, 63, 63, '0, '0);
        push_word(CMD_WR_A, 63, 63, $urandom, $urandom);
        push_word(CMD_RD_C, 0, 63, '0, '0);
        push_word(CMD_RD_C, 63, 0, '0, '0);
        push_word(CMD_NOP_5, 63, 63, '1, '1);
        push_word(CMD_NOP_6, 0, 0, $urandom, $urandom);
        push_word(CMD_NOP_7, 63, 0, $urandom, $urandom);
        push_word(CMD_RD_C, 0, 0, '0, '0);
        push_word(CMD_WR_A, 0, 0, '1, '0);
        push_word(CMD_WR_C, 0, 0, '0, '0);
        push_word(CMD_RUN, 0, 0, '0, '0);
        push_word(CMD_RD_C, 0, 0, '0, '0);
        drain();

        phase = 0;
        while (word_count < WORD_TARGET) begin
            k     = $urandom_range(0, 2);
            style = value_style_t'($urandom_range(0, 2));
            case (phase)
                0: begin mode = DIMS_OVER; k = 0; end
                1: begin mode = DIMS_FULL; k = 1; end
                2: begin mode = DIMS_OVER; k = 2; end
                3: mode = DIMS_ZERO;
                default: begin
                    r = $urandom_range(0, 31);
                    if (r < 2)       mode = DIMS_ZERO;
                    else if (r == 2) mode = DIMS_OVER;
                    else if (r == 3) mode = DIMS_FULL;
                    else if (r < 7)  mode = DIMS_MEDIUM;
                    else             mode = DIMS_SMALL;
                end
            endcase
            for (int i = 0; i < 3; i++) begin
                case (mode)
                    DIMS_OVER, DIMS_FULL: d[i] = 1;
                    DIMS_MEDIUM:          d[i] = $urandom_range(5, 8);
                    default:              d[i] = $urandom_range(1, 4);
                endcase
            end
            case (mode)
                DIMS_ZERO: d[k] = 0;
                DIMS_OVER: d[k] = (phase == 0) ? 127 : $urandom_range(65, 127);
                DIMS_FULL: d[k] = MAX_DIM;
                default: ;
            endcase
            calm = (word_count >= WORD_TARGET * 7 / 8);

            write_reg(CFG_ROWS_OF_A, DIM_W'(d[0]));
            write_reg(CFG_INNER_LENGTH, DIM_W'(d[1]));
            write_reg(CFG_COLS_OF_B, DIM_W'(d[2]));
            if (phase == 0) write_reg(CFG_SPARE, DIM_W'($urandom));

            em = eff_dim(d[0]);
            en = eff_dim(d[1]);
            ep = eff_dim(d[2]);
            for (int m = 0; m < em; m++)
                for (int n = 0; n < en; n++)
                    fill_entry(CMD_WR_A, m, n, a_known[m * MAX_DIM + n], style);
            for (int n = 0; n < en; n++)
                for (int p = 0; p < ep; p++)
                    fill_entry(CMD_WR_B, n, p, b_known[n * MAX_DIM + p], style);
            for (int m = 0; m < em; m++)
                for (int p = 0; p < ep; p++)
                    fill_entry(CMD_WR_C, m, p, c_known[m * MAX_DIM + p], style);

            runs = $urandom_range(1, 2);
            for (int i = 0; i < runs; i++) begin
                push_word(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom, $urandom);
                if ($urandom_range(0, 1) == 0) push_read_known();
            end
            repeat ($urandom_range(1, 6)) begin
                if (em != 0 && ep != 0) begin
                    push_word(CMD_RD_C, $urandom_range(0, em - 1), $urandom_range(0, ep - 1),
                              $urandom, $urandom);
                end else begin
                    push_read_known();
                end
            end
            drain();
            phase++;
        end

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cmma_pkg.sv
hw/rtl/cmma_in_if.sv
hw/rtl/cmma_out_if.sv
hw/rtl/cmma_mac_unit.sv
hw/rtl/complex_matrix_multiply_accumulate.sv
test/complex_matrix_multiply_accumulate_tb.sv
